@@ rtl/ffa_pkg.sv @@
// Shared types and constants of the first-fit extent allocator.
// No dependencies; used by ffa_cell, ffa_ctrl and the top level.
package ffa_pkg;

   localparam int RUN_TABLE_DEPTH = 256;
   localparam int IDX_BITS        = $clog2(RUN_TABLE_DEPTH);
   localparam int FILL_BITS       = $clog2(RUN_TABLE_DEPTH + 1);
   localparam int BLOCK_BITS      = 32;
   localparam int REQ_BITS        = BLOCK_BITS + 1;
   localparam int DIV_STEPS       = 2;
   localparam int CNT_BITS        = $clog2(DIV_STEPS);
   localparam logic [31:0] FIRST_INODE_RESET = 32'd11;
   // floor(x / 10) == (x * RECIP_TEN) >> 35 for every 32-bit x
   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

   typedef enum logic [1:0] {
      FUNC_SCAN  = 2'd0,
      FUNC_END   = 2'd1,
      FUNC_ALLOC = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      STATUS_ACCEPTED  = 3'd0,
      STATUS_ALLOCATED = 3'd1,
      STATUS_SKIPPED   = 3'd2,
      STATUS_NO_FIT    = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_GROWTH_ENABLE = 1'b0,
      CSR_FIRST_INODE   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_STORE  = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SEARCH,
      ST_WAIT,
      ST_COMMIT
   } state_type;

   // packet travelling down the cell chain
   typedef struct packed {
      op_type                  op;
      logic [BLOCK_BITS-1:0]   start;
      logic [REQ_BITS-1:0]     len;
      logic                    done;
      logic                    found;
      logic [BLOCK_BITS-1:0]   best_start;
      logic [BLOCK_BITS-1:0]   best_len;
      logic [IDX_BITS-1:0]     best_idx;
   } pkt_type;

   // broadcast from controller to all cells
   typedef struct packed {
      logic                    clear;
      logic                    en;
      logic                    kill;
      logic [IDX_BITS-1:0]     idx;
      logic [BLOCK_BITS-1:0]   start;
      logic [BLOCK_BITS-1:0]   len;
   } cmd_type;

endpackage

@@ rtl/ffa_cell.sv @@
// One extent slot of the run table, one stage of the packet chain.
// Depends on ffa_pkg.
module ffa_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ffa_pkg::IDX_BITS-1:0]  idx,
   input  ffa_pkg::pkt_type              pkt_i,
   input  ffa_pkg::cmd_type              cmd_i,
   output ffa_pkg::pkt_type              pkt_o
);

   logic                            valid_ff, valid_in;
   logic [ffa_pkg::BLOCK_BITS-1:0]  start_ff, start_in;
   logic [ffa_pkg::BLOCK_BITS-1:0]  len_ff, len_in;
   ffa_pkg::pkt_type                pkt_ff, pkt_in;

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      len_in   = len_ff;
      pkt_in   = pkt_i;
      unique case (pkt_i.op)
         ffa_pkg::OP_STORE: begin
            if (!valid_ff && !pkt_i.done) begin
               valid_in    = 1'b1;
               start_in    = pkt_i.start;
               len_in      = pkt_i.len[ffa_pkg::BLOCK_BITS-1:0];
               pkt_in.done = 1'b1;
            end
         end
         ffa_pkg::OP_SEARCH: begin
            if (valid_ff && ({1'b0, len_ff} >= pkt_i.len) &&
                (!pkt_i.found || start_ff < pkt_i.best_start)) begin
               pkt_in.found      = 1'b1;
               pkt_in.best_start = start_ff;
               pkt_in.best_len   = len_ff;
               pkt_in.best_idx   = idx;
            end
         end
         default: begin
         end
      endcase
      if (cmd_i.clear) begin
         valid_in = 1'b0;
      end else if (cmd_i.en && cmd_i.idx == idx) begin
         if (cmd_i.kill) begin
            valid_in = 1'b0;
         end else begin
            start_in = cmd_i.start;
            len_in   = cmd_i.len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         pkt_ff.op <= ffa_pkg::OP_NONE;
      end else begin
         valid_ff  <= valid_in;
         pkt_ff.op <= pkt_in.op;
      end
      start_ff          <= start_in;
      len_ff            <= len_in;
      pkt_ff.start      <= pkt_in.start;
      pkt_ff.len        <= pkt_in.len;
      pkt_ff.done       <= pkt_in.done;
      pkt_ff.found      <= pkt_in.found;
      pkt_ff.best_start <= pkt_in.best_start;
      pkt_ff.best_len   <= pkt_in.best_len;
      pkt_ff.best_idx   <= pkt_in.best_idx;
   end

   assign pkt_o = pkt_ff;

endmodule

@@ rtl/ffa_ctrl.sv @@
// Controller: run tracking, reserve divider, chain launch and commit, result register.
// Depends on ffa_pkg.
module ffa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic [31:0]                   req_block_number,
   input  logic                          req_block_movable,
   input  logic                          req_block_allocated,
   input  logic [31:0]                   req_inode_number,
   input  logic                          req_is_file_kind,
   input  logic [31:0]                   req_allocation_count,
   input  logic [31:0]                   req_data_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [31:0]                   rsp_target_start,
   output logic [31:0]                   rsp_reserve_start,
   output logic [31:0]                   rsp_reserve_blocks,
   input  logic                          csr_write_enable,
   input  logic [0:0]                    csr_index,
   input  logic [31:0]                   csr_write_data,
   output ffa_pkg::pkt_type              pkt_o,
   input  ffa_pkg::pkt_type              pkt_i,
   output ffa_pkg::cmd_type              cmd_o
);

   ffa_pkg::state_type state_ff, state_in;

   logic                            gre_ff, gre_in;
   logic [31:0]                     foi_ff, foi_in;
   logic                            open_ff, open_in;
   logic [31:0]                     rstart_ff, rstart_in;
   logic [31:0]                     rlast_ff, rlast_in;
   logic [ffa_pkg::FILL_BITS-1:0]   fill_ff, fill_in;
   logic [31:0]                     alloc_ff, alloc_in;
   logic                            use_res_ff, use_res_in;
   logic [63:0]                     div_ff, div_in;
   logic [31:0]                     dat_ff, dat_in;
   logic [ffa_pkg::CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [31:0]                     res_ff, res_in;
   logic [ffa_pkg::REQ_BITS-1:0]    need_ff, need_in;
   logic [31:0]                     bstart_ff, bstart_in;
   logic [31:0]                     blen_ff, blen_in;
   logic [ffa_pkg::IDX_BITS-1:0]    bidx_ff, bidx_in;
   logic                            rv_ff, rv_in;
   ffa_pkg::status_type             st_ff, st_in;
   logic [31:0]                     tgt_ff, tgt_in;
   logic [31:0]                     rsv_ff, rsv_in;
   logic [31:0]                     rcnt_ff, rcnt_in;

   logic        accept;
   logic        usable, follow, closing, run_nz, do_store, full;
   logic [31:0] run_len;
   logic [28:0] quo;
   logic [31:0] quo_ten, quo_ceil;
   logic        div_last;
   logic [31:0] reserve;

   assign req_stall = (state_ff != ffa_pkg::ST_IDLE) || rv_ff;
   assign accept    = req_valid && !req_stall;
   assign usable    = req_block_movable || !req_block_allocated;
   assign follow    = open_ff && (req_block_number == rlast_ff + 32'd1);
   assign run_len   = rlast_ff - rstart_ff + 32'd1;
   assign run_nz    = run_len != 32'd0;
   // ceil(data / 10) from the registered reciprocal product
   assign quo       = div_ff[63:35];
   assign quo_ten   = {quo, 3'b000} + {2'b00, quo, 1'b0};
   assign quo_ceil  = {3'b000, quo} + {31'd0, quo_ten != dat_ff};
   assign div_last  = cnt_ff == ffa_pkg::CNT_BITS'(ffa_pkg::DIV_STEPS - 1);
   assign reserve   = use_res_ff ? div_ff[31:0] : 32'd0;

   always_comb begin
      unique case (ffa_pkg::func_type'(req_func))
         ffa_pkg::FUNC_SCAN: closing = usable ? (open_ff && !follow) : open_ff;
         ffa_pkg::FUNC_END:  closing = open_ff;
         default:            closing = 1'b0;
      endcase
      do_store = closing && run_nz && (fill_ff < ffa_pkg::FILL_BITS'(ffa_pkg::RUN_TABLE_DEPTH));
      full     = closing && run_nz && !do_store;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (ffa_pkg::func_type'(req_func))
                  ffa_pkg::FUNC_SCAN, ffa_pkg::FUNC_END:
                     state_in = do_store ? ffa_pkg::ST_WAIT : ffa_pkg::ST_IDLE;
                  ffa_pkg::FUNC_ALLOC: begin
                     if (req_allocation_count == 32'd0)
                        state_in = ffa_pkg::ST_IDLE;
                     else if (gre_ff && req_is_file_kind && req_inode_number >= foi_ff &&
                              req_data_count != 32'd0)
                        state_in = ffa_pkg::ST_DIV;
                     else
                        state_in = ffa_pkg::ST_SEARCH;
                  end
                  default: state_in = ffa_pkg::ST_IDLE;
               endcase
            end
         end
         ffa_pkg::ST_DIV:    if (div_last) state_in = ffa_pkg::ST_SEARCH;
         ffa_pkg::ST_SEARCH: state_in = ffa_pkg::ST_WAIT;
         ffa_pkg::ST_WAIT: begin
            if (pkt_i.op == ffa_pkg::OP_STORE)
               state_in = ffa_pkg::ST_IDLE;
            else if (pkt_i.op == ffa_pkg::OP_SEARCH)
               state_in = pkt_i.found ? ffa_pkg::ST_COMMIT : ffa_pkg::ST_IDLE;
         end
         ffa_pkg::ST_COMMIT: state_in = ffa_pkg::ST_IDLE;
         default:            state_in = ffa_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      gre_in     = gre_ff;
      foi_in     = foi_ff;
      open_in    = open_ff;
      rstart_in  = rstart_ff;
      rlast_in   = rlast_ff;
      fill_in    = fill_ff;
      alloc_in   = alloc_ff;
      use_res_in = use_res_ff;
      div_in     = div_ff;
      dat_in     = dat_ff;
      cnt_in     = cnt_ff;
      res_in     = res_ff;
      need_in    = need_ff;
      bstart_in  = bstart_ff;
      blen_in    = blen_ff;
      bidx_in    = bidx_ff;
      rv_in      = rv_ff && rsp_stall;
      st_in      = st_ff;
      tgt_in     = tgt_ff;
      rsv_in     = rsv_ff;
      rcnt_in    = rcnt_ff;
      pkt_o      = '0;
      pkt_o.op   = ffa_pkg::OP_NONE;
      cmd_o      = '0;

      if (csr_write_enable) begin
         unique case (ffa_pkg::csr_index_type'(csr_index))
            ffa_pkg::CSR_GROWTH_ENABLE: gre_in = csr_write_data[0];
            ffa_pkg::CSR_FIRST_INODE:   foi_in = csr_write_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ffa_pkg::ST_IDLE: begin
            if (accept) begin
               st_in   = ffa_pkg::STATUS_ACCEPTED;
               tgt_in  = 32'd0;
               rsv_in  = 32'd0;
               rcnt_in = 32'd0;
               unique case (ffa_pkg::func_type'(req_func))
                  ffa_pkg::FUNC_SCAN, ffa_pkg::FUNC_END: begin
                     rv_in = 1'b1;
                     if (full) st_in = ffa_pkg::STATUS_FULL;
                     if (do_store) begin
                        pkt_o.op    = ffa_pkg::OP_STORE;
                        pkt_o.start = rstart_ff;
                        pkt_o.len   = {1'b0, run_len};
                        fill_in     = fill_ff + 1'b1;
                     end
                     if (ffa_pkg::func_type'(req_func) == ffa_pkg::FUNC_END) begin
                        open_in = 1'b0;
                     end else if (usable) begin
                        open_in  = 1'b1;
                        rlast_in = req_block_number;
                        if (!follow) rstart_in = req_block_number;
                     end else begin
                        open_in = 1'b0;
                     end
                  end
                  ffa_pkg::FUNC_ALLOC: begin
                     alloc_in   = req_allocation_count;
                     use_res_in = gre_ff && req_is_file_kind && req_inode_number >= foi_ff &&
                                  req_data_count != 32'd0;
                     dat_in     = req_data_count;
                     cnt_in     = '0;
                     if (req_allocation_count == 32'd0) begin
                        rv_in = 1'b1;
                        st_in = ffa_pkg::STATUS_SKIPPED;
                     end
                  end
                  default: begin
                     rv_in       = 1'b1;
                     cmd_o.clear = 1'b1;
                     fill_in     = '0;
                     open_in     = 1'b0;
                     rstart_in   = 32'd0;
                     rlast_in    = 32'd0;
                  end
               endcase
            end
         end
         ffa_pkg::ST_DIV: begin
            if (div_last)
               div_in = {32'd0, quo_ceil};
            else
               div_in = {32'd0, dat_ff} * {32'd0, ffa_pkg::RECIP_TEN};
            cnt_in = cnt_ff + 1'b1;
         end
         ffa_pkg::ST_SEARCH: begin
            res_in     = reserve;
            need_in    = {1'b0, alloc_ff} + {1'b0, reserve};
            pkt_o.op   = ffa_pkg::OP_SEARCH;
            pkt_o.len  = {1'b0, alloc_ff} + {1'b0, reserve};
         end
         ffa_pkg::ST_WAIT: begin
            if (pkt_i.op == ffa_pkg::OP_SEARCH) begin
               bstart_in = pkt_i.best_start;
               blen_in   = pkt_i.best_len;
               bidx_in   = pkt_i.best_idx;
               if (!pkt_i.found) begin
                  rv_in = 1'b1;
                  st_in = ffa_pkg::STATUS_NO_FIT;
               end
            end
         end
         ffa_pkg::ST_COMMIT: begin
            cmd_o.en    = 1'b1;
            cmd_o.idx   = bidx_ff;
            cmd_o.kill  = {1'b0, blen_ff} == need_ff;
            cmd_o.start = bstart_ff + need_ff[31:0];
            cmd_o.len   = blen_ff - need_ff[31:0];
            if ({1'b0, blen_ff} == need_ff) fill_in = fill_ff - 1'b1;
            rv_in   = 1'b1;
            st_in   = ffa_pkg::STATUS_ALLOCATED;
            tgt_in  = bstart_ff;
            rcnt_in = res_ff;
            rsv_in  = (res_ff != 32'd0) ? bstart_ff + alloc_ff : 32'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ffa_pkg::ST_IDLE;
         gre_ff    <= 1'b0;
         foi_ff    <= ffa_pkg::FIRST_INODE_RESET;
         open_ff   <= 1'b0;
         rstart_ff <= 32'd0;
         rlast_ff  <= 32'd0;
         fill_ff   <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         gre_ff    <= gre_in;
         foi_ff    <= foi_in;
         open_ff   <= open_in;
         rstart_ff <= rstart_in;
         rlast_ff  <= rlast_in;
         fill_ff   <= fill_in;
         rv_ff     <= rv_in;
      end
      alloc_ff   <= alloc_in;
      use_res_ff <= use_res_in;
      div_ff     <= div_in;
      dat_ff     <= dat_in;
      cnt_ff     <= cnt_in;
      res_ff     <= res_in;
      need_ff    <= need_in;
      bstart_ff  <= bstart_in;
      blen_ff    <= blen_in;
      bidx_ff    <= bidx_in;
      st_ff      <= st_in;
      tgt_ff     <= tgt_in;
      rsv_ff     <= rsv_in;
      rcnt_ff    <= rcnt_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_status         = st_ff;
   assign rsp_target_start   = tgt_ff;
   assign rsp_reserve_start  = rsv_ff;
   assign rsp_reserve_blocks = rcnt_ff;

endmodule

@@ rtl/free_run_first_fit_allocator.sv @@
// Top level of the first-fit extent allocator: controller plus a chain of table cells.
// Depends on ffa_pkg, ffa_cell and ffa_ctrl.
//
// One item at a time. Scan and end-of-scan items answer in the next cycle; one that stores a
// closed run then keeps the input stalled while the store packet walks the whole cell chain
// and is taken by the first free slot. Clear and zero-count items also answer in the next
// cycle. An allocate item keeps the input stalled while the search packet passes every
// cell, then the commit, which is skipped when no run fits; the reciprocal divide by ten
// comes first when a growth reserve is computed. The result register must be empty
// before the next item is taken.
module free_run_first_fit_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [31:0] req_block_number,
   input  logic        req_block_movable,
   input  logic        req_block_allocated,
   input  logic [31:0] req_inode_number,
   input  logic        req_is_file_kind,
   input  logic [31:0] req_allocation_count,
   input  logic [31:0] req_data_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_target_start,
   output logic [31:0] rsp_reserve_start,
   output logic [31:0] rsp_reserve_blocks,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   ffa_pkg::pkt_type chain [ffa_pkg::RUN_TABLE_DEPTH+1];
   ffa_pkg::cmd_type cmd;

   ffa_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_block_number     (req_block_number),
      .req_block_movable    (req_block_movable),
      .req_block_allocated  (req_block_allocated),
      .req_inode_number     (req_inode_number),
      .req_is_file_kind     (req_is_file_kind),
      .req_allocation_count (req_allocation_count),
      .req_data_count       (req_data_count),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_target_start     (rsp_target_start),
      .rsp_reserve_start    (rsp_reserve_start),
      .rsp_reserve_blocks   (rsp_reserve_blocks),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .pkt_o                (chain[0]),
      .pkt_i                (chain[ffa_pkg::RUN_TABLE_DEPTH]),
      .cmd_o                (cmd)
   );

   for (genvar i = 0; i < ffa_pkg::RUN_TABLE_DEPTH; i++) begin : g_cell
      ffa_cell u_cell (
         .clock (clock),
         .reset (reset),
         .idx   (ffa_pkg::IDX_BITS'(i)),
         .pkt_i (chain[i]),
         .cmd_i (cmd),
         .pkt_o (chain[i+1])
      );
   end

endmodule
